FILE: rtl/spanning_tree_count_mod_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the spanning tree counter.
// ---------------------------------------------------------------------------
`ifndef SPANNING_TREE_COUNT_MOD_MACROS_SVH
`define SPANNING_TREE_COUNT_MOD_MACROS_SVH

// Checked on every edge outside reset.
`define STC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define STC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/stc_pkg.sv
// ---------------------------------------------------------------------------
// stc_pkg
// Types, codes and sizes shared by the spanning tree counter modules.
// ---------------------------------------------------------------------------
package stc_pkg;

  localparam int MAX_NODES = 64;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int DEPTH     = MAX_NODES * MAX_NODES;
  localparam int DATA_W    = 30;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NC_W      = 7;
  localparam int EP_W      = 6;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 1'd1;

  localparam logic [NC_W-1:0]   NODE_COUNT_RST = 7'd1;
  localparam logic [DATA_W-1:0] MODULUS_RST    = 30'd1000000000;

  // Memory write data selection.
  localparam logic [2:0] WS_ZERO = 3'd0;
  localparam logic [2:0] WS_BUMP = 3'd1;
  localparam logic [2:0] WS_Y    = 3'd2;
  localparam logic [2:0] WS_V    = 3'd3;
  localparam logic [2:0] WS_REM  = 3'd4;

  // Divider operand selection.
  localparam logic [1:0] DOP_RED = 2'd0;
  localparam logic [1:0] DOP_QUO = 2'd1;
  localparam logic [1:0] DOP_MUL = 2'd2;

  // Running product updates.
  localparam logic [1:0] RES_HOLD = 2'd0;
  localparam logic [1:0] RES_INIT = 2'd1;
  localparam logic [1:0] RES_NEG  = 2'd2;
  localparam logic [1:0] RES_LD   = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              we;
    logic [2:0]        wsel;
    logic              ld_x;
    logic              ld_y;
    logic              ld_t;
    logic              ld_p;
    logic              mul_sel;
    logic              div_start;
    logic [1:0]        div_op;
    logic              up;
    logic [1:0]        res_op;
    logic              ld_out;
  } stc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic y_zero;
  } stc_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    cell_addr = {row, col};
  endfunction

endpackage

FILE: rtl/stc_ram.sv
// ---------------------------------------------------------------------------
// stc_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module stc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/stc_div.sv
// ---------------------------------------------------------------------------
// stc_div
// Restoring divider, one quotient bit per cycle, 60-bit dividend.
// ---------------------------------------------------------------------------
module stc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [stc_pkg::PROD_W-1:0] dividend,
  input  logic [stc_pkg::DATA_W-1:0] divisor,
  output logic                      done,
  output logic [stc_pkg::DATA_W-1:0] quo,
  output logic [stc_pkg::DATA_W-1:0] rem
);

  localparam int CW = $clog2(stc_pkg::PROD_W + 1);

  logic [stc_pkg::PROD_W-1:0] dvd_r;
  logic [stc_pkg::DATA_W-1:0] dvs_r, rem_r, quo_r;
  logic [CW-1:0]              cnt_r;
  logic                       busy_r, done_r;
  logic [stc_pkg::DATA_W:0]   tmp;
  logic                       ge;

  assign tmp = {rem_r, dvd_r[stc_pkg::PROD_W-1]};
  assign ge  = tmp >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(stc_pkg::PROD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? stc_pkg::DATA_W'(tmp - {1'b0, dvs_r}) : stc_pkg::DATA_W'(tmp);
      quo_r <= {quo_r[stc_pkg::DATA_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/stc_dp.sv
// ---------------------------------------------------------------------------
// stc_dp
// Datapath: matrix memory, operand registers, multiplier and divider.
// ---------------------------------------------------------------------------
module stc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stc_pkg::stc_cmd_t          cmd,
  input  logic [stc_pkg::DATA_W-1:0] m_eff,
  output stc_pkg::stc_stat_t         stat,
  output logic [stc_pkg::DATA_W-1:0] tree_count
);

  localparam int DW = stc_pkg::DATA_W;

  logic [DW-1:0]              rdata, wdata;
  logic [DW-1:0]              x_r, y_r, t_r, res_r, out_r;
  logic [stc_pkg::PROD_W-1:0] p_r;
  logic [stc_pkg::PROD_W-1:0] dividend;
  logic [DW-1:0]              divisor, quo, rem;
  logic                       div_done;
  logic [DW:0]                r_inc, v_sum;
  logic [DW-1:0]              bump_val, v_val;

  stc_ram #(.WIDTH(DW), .DEPTH(stc_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .addr  (cmd.addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  always_comb begin
    case (cmd.div_op)
      stc_pkg::DOP_MUL: dividend = p_r;
      default:          dividend = {{DW{1'b0}}, x_r};
    endcase
    divisor = (cmd.div_op == stc_pkg::DOP_QUO) ? y_r : m_eff;
  end

  stc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // Residue plus or minus one, and the row update x - t*y in residues.
  assign r_inc    = {1'b0, rem} + 1'b1;
  assign bump_val = cmd.up ? ((r_inc == {1'b0, m_eff}) ? '0 : DW'(r_inc))
                           : ((rem == '0) ? m_eff - 1'b1 : rem - 1'b1);
  assign v_sum    = {1'b0, x_r} + {1'b0, m_eff} - {1'b0, rem};
  assign v_val    = (x_r >= rem) ? x_r - rem : DW'(v_sum);

  always_comb begin
    case (cmd.wsel)
      stc_pkg::WS_BUMP: wdata = bump_val;
      stc_pkg::WS_Y:    wdata = y_r;
      stc_pkg::WS_V:    wdata = v_val;
      stc_pkg::WS_REM:  wdata = rem;
      default:          wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_x) x_r <= rdata;
    if (cmd.ld_y) y_r <= rdata;
    if (cmd.ld_t) t_r <= quo;
    if (cmd.ld_p) p_r <= cmd.mul_sel ? res_r * x_r : t_r * y_r;
    if (cmd.ld_out) out_r <= res_r;
    case (cmd.res_op)
      stc_pkg::RES_INIT: res_r <= (m_eff == DW'(1)) ? '0 : DW'(1);
      stc_pkg::RES_NEG:  res_r <= (res_r == '0) ? '0 : m_eff - res_r;
      stc_pkg::RES_LD:   res_r <= rem;
      default:           res_r <= res_r;
    endcase
  end

  assign stat.div_done = div_done;
  assign stat.y_zero   = (y_r == '0);
  assign tree_count    = out_r;

endmodule

FILE: rtl/stc_ctrl.sv
// ---------------------------------------------------------------------------
// stc_ctrl
// Sequencer for edge loading, elimination, result hand-off and clearing.
// ---------------------------------------------------------------------------
module stc_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_mode,
  input  logic [stc_pkg::EP_W-1:0]  in_endpoint_a,
  input  logic [stc_pkg::EP_W-1:0]  in_endpoint_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic [stc_pkg::CNT_W-1:0] n_eff,
  input  stc_pkg::stc_stat_t        stat,
  output stc_pkg::stc_cmd_t         cmd
);

  localparam int IW = stc_pkg::IDX_W;

  localparam logic [5:0] S_CLR   = 6'd0;
  localparam logic [5:0] S_IDLE  = 6'd1;
  localparam logic [5:0] S_B_RD  = 6'd2;
  localparam logic [5:0] S_B_LD  = 6'd3;
  localparam logic [5:0] S_B_DIV = 6'd4;
  localparam logic [5:0] S_B_WT  = 6'd5;
  localparam logic [5:0] S_B_WR  = 6'd6;
  localparam logic [5:0] S_N_RD  = 6'd7;
  localparam logic [5:0] S_N_LD  = 6'd8;
  localparam logic [5:0] S_N_DIV = 6'd9;
  localparam logic [5:0] S_N_WT  = 6'd10;
  localparam logic [5:0] S_N_WR  = 6'd11;
  localparam logic [5:0] S_E_COL = 6'd12;
  localparam logic [5:0] S_E_RDJ = 6'd13;
  localparam logic [5:0] S_E_LDJ = 6'd14;
  localparam logic [5:0] S_E_CHK = 6'd15;
  localparam logic [5:0] S_E_RDI = 6'd16;
  localparam logic [5:0] S_E_LDI = 6'd17;
  localparam logic [5:0] S_E_DIV = 6'd18;
  localparam logic [5:0] S_E_WT  = 6'd19;
  localparam logic [5:0] S_K_RDI = 6'd20;
  localparam logic [5:0] S_K_LDI = 6'd21;
  localparam logic [5:0] S_K_RDJ = 6'd22;
  localparam logic [5:0] S_K_LDJ = 6'd23;
  localparam logic [5:0] S_K_MUL = 6'd24;
  localparam logic [5:0] S_K_DIV = 6'd25;
  localparam logic [5:0] S_K_WT  = 6'd26;
  localparam logic [5:0] S_K_WRI = 6'd27;
  localparam logic [5:0] S_K_WRJ = 6'd28;
  localparam logic [5:0] S_P_RD  = 6'd29;
  localparam logic [5:0] S_P_LD  = 6'd30;
  localparam logic [5:0] S_P_MUL = 6'd31;
  localparam logic [5:0] S_P_DIV = 6'd32;
  localparam logic [5:0] S_P_WT  = 6'd33;
  localparam logic [5:0] S_DONE  = 6'd34;

  logic [5:0]                state_r, state_nxt;
  logic [IW-1:0]             i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IW-1:0]             a_r, a_nxt, b_r, b_nxt;
  logic [1:0]                q_r, q_nxt;
  logic [stc_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic                      ov_r, ov_nxt;
  logic [IW-1:0]             dim, dim_m1;
  logic                      edge_ok;
  logic [stc_pkg::ADDR_W-1:0] bump_addr;

  assign dim    = (n_eff == '0) ? '0 : IW'(n_eff - 1'b1);
  assign dim_m1 = dim - 1'b1;
  assign edge_ok = (int'(in_endpoint_a) < int'(n_eff)) &&
                   (int'(in_endpoint_b) < int'(n_eff)) &&
                   (in_endpoint_a != in_endpoint_b);

  always_comb begin
    case (q_r)
      2'd0:    bump_addr = stc_pkg::cell_addr(a_r, a_r);
      2'd1:    bump_addr = stc_pkg::cell_addr(b_r, b_r);
      2'd2:    bump_addr = stc_pkg::cell_addr(a_r, b_r);
      default: bump_addr = stc_pkg::cell_addr(b_r, a_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    a_nxt = a_r;
    b_nxt = b_r;
    q_nxt = q_r;
    clr_nxt = clr_r;
    ov_nxt = ov_r;
    cmd = '0;
    cmd.wsel = stc_pkg::WS_ZERO;
    cmd.div_op = stc_pkg::DOP_RED;
    cmd.res_op = stc_pkg::RES_HOLD;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_CLR: begin
        cmd.addr = clr_r;
        cmd.we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          a_nxt = IW'(in_endpoint_a);
          b_nxt = IW'(in_endpoint_b);
          q_nxt = '0;
          i_nxt = '0;
          j_nxt = IW'(1);
          k_nxt = '0;
          if (in_mode) begin
            cmd.res_op = stc_pkg::RES_INIT;
            state_nxt = (dim == '0) ? S_DONE : S_N_RD;
          end else if (edge_ok) begin
            state_nxt = S_B_RD;
          end
        end
      end
      S_B_RD: begin
        cmd.addr = bump_addr;
        state_nxt = S_B_LD;
      end
      S_B_LD: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_B_DIV;
      end
      S_B_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_B_WT;
      end
      S_B_WT: begin
        if (stat.div_done) state_nxt = S_B_WR;
      end
      S_B_WR: begin
        cmd.addr = bump_addr;
        cmd.we = 1'b1;
        cmd.wsel = stc_pkg::WS_BUMP;
        cmd.up = ~q_r[1];
        q_nxt = q_r + 1'b1;
        state_nxt = (q_r == 2'd3) ? S_IDLE : S_B_RD;
      end
      S_N_RD: begin
        cmd.addr = stc_pkg::cell_addr(i_r, k_r);
        state_nxt = S_N_LD;
      end
      S_N_LD: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_N_DIV;
      end
      S_N_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt = S_N_WT;
      end
      S_N_WT: begin
        if (stat.div_done) state_nxt = S_N_WR;
      end
      S_N_WR: begin
        cmd.addr = stc_pkg::cell_addr(i_r, k_r);
        cmd.we = 1'b1;
        cmd.wsel = stc_pkg::WS_REM;
        state_nxt = S_N_RD;
        if (k_r == dim_m1) begin
          k_nxt = '0;
          if (i_r == dim_m1) begin
            i_nxt = '0;
            state_nxt = S_E_COL;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_E_COL: begin
        state_nxt = (j_r < dim) ? S_E_RDJ : S_P_RD;
      end
      S_E_RDJ: begin
        cmd.addr = stc_pkg::cell_addr(j_r, i_r);
        state_nxt = S_E_LDJ;
      end
      S_E_LDJ: begin
        cmd.ld_y = 1'b1;
        state_nxt = S_E_CHK;
      end
      S_E_CHK: begin
        if (stat.y_zero) begin
          j_nxt = j_r + 1'b1;
          state_nxt = S_E_COL;
        end else begin
          state_nxt = S_E_RDI;
        end
      end
      S_E_RDI: begin
        cmd.addr = stc_pkg::cell_addr(i_r, i_r);
        state_nxt = S_E_LDI;
      end
      S_E_LDI: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_E_DIV;
      end
      S_E_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op = stc_pkg::DOP_QUO;
        state_nxt = S_E_WT;
      end
      S_E_WT: begin
        cmd.div_op = stc_pkg::DOP_QUO;
        if (stat.div_done) begin
          cmd.ld_t = 1'b1;
          k_nxt = i_r;
          state_nxt = S_K_RDI;
        end
      end
      S_K_RDI: begin
        cmd.addr = stc_pkg::cell_addr(i_r, k_r);
        state_nxt = S_K_LDI;
      end
      S_K_LDI: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_K_RDJ;
      end
      S_K_RDJ: begin
        cmd.addr = stc_pkg::cell_addr(j_r, k_r);
        state_nxt = S_K_LDJ;
      end
      S_K_LDJ: begin
        cmd.ld_y = 1'b1;
        state_nxt = S_K_MUL;
      end
      S_K_MUL: begin
        cmd.ld_p = 1'b1;
        state_nxt = S_K_DIV;
      end
      S_K_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op = stc_pkg::DOP_MUL;
        state_nxt = S_K_WT;
      end
      S_K_WT: begin
        cmd.div_op = stc_pkg::DOP_MUL;
        if (stat.div_done) state_nxt = S_K_WRI;
      end
      S_K_WRI: begin
        cmd.addr = stc_pkg::cell_addr(i_r, k_r);
        cmd.we = 1'b1;
        cmd.wsel = stc_pkg::WS_Y;
        state_nxt = S_K_WRJ;
      end
      S_K_WRJ: begin
        cmd.addr = stc_pkg::cell_addr(j_r, k_r);
        cmd.we = 1'b1;
        cmd.wsel = stc_pkg::WS_V;
        if (k_r == dim_m1) begin
          cmd.res_op = stc_pkg::RES_NEG;
          state_nxt = S_E_RDJ;
        end else begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_K_RDI;
        end
      end
      S_P_RD: begin
        cmd.addr = stc_pkg::cell_addr(i_r, i_r);
        state_nxt = S_P_LD;
      end
      S_P_LD: begin
        cmd.ld_x = 1'b1;
        state_nxt = S_P_MUL;
      end
      S_P_MUL: begin
        cmd.ld_p = 1'b1;
        cmd.mul_sel = 1'b1;
        state_nxt = S_P_DIV;
      end
      S_P_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_op = stc_pkg::DOP_MUL;
        state_nxt = S_P_WT;
      end
      S_P_WT: begin
        cmd.div_op = stc_pkg::DOP_MUL;
        if (stat.div_done) begin
          cmd.res_op = stc_pkg::RES_LD;
          if (i_r == dim_m1) begin
            state_nxt = S_DONE;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + IW'(2);
            state_nxt = S_E_COL;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.ld_out = 1'b1;
          ov_nxt = 1'b1;
          clr_nxt = '0;
          state_nxt = S_CLR;
        end
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      ov_r    <= 1'b0;
      q_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
      q_r     <= q_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

endmodule

FILE: rtl/spanning_tree_count_mod.sv
// ---------------------------------------------------------------------------
// spanning_tree_count_mod
// Spanning tree counter by the matrix-tree theorem over residues.
// ---------------------------------------------------------------------------
//
//   channel  handshake            payload
//   in       in_valid/in_ready    in_mode, in_endpoint_a, in_endpoint_b
//   out      out_valid/out_ready  out_tree_count
//   cfg      cfg_we               cfg_index, cfg_data
//
// An edge word takes four read-modify-writes of the matrix memory, each one
// waiting on the divider, since every stored entry is reduced by it.
// A determinant word first reduces every entry of the d-by-d minor, then
// eliminates by row division, with the pace of each entry it touches set by
// the shared divider and the single memory port; then all 4096 entries clear.
// After reset a clearing pass over all 4096 entries runs before the first word.
// A stalled result waits in its own register while edge words are taken.
//
module spanning_tree_count_mod (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [stc_pkg::EP_W-1:0]      in_endpoint_a,
  input  logic [stc_pkg::EP_W-1:0]      in_endpoint_b,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stc_pkg::DATA_W-1:0]    out_tree_count,
  input  logic                          cfg_we,
  input  logic [stc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stc_pkg::DATA_W-1:0]    cfg_data
);

`include "spanning_tree_count_mod_macros.svh"

  logic [stc_pkg::NC_W-1:0]   node_count_r;
  logic [stc_pkg::DATA_W-1:0] modulus_r;
  logic [stc_pkg::DATA_W-1:0] m_eff;
  logic [stc_pkg::CNT_W-1:0]  n_eff;
  stc_pkg::stc_cmd_t          cmd;
  stc_pkg::stc_stat_t         stat;

  // Configuration registers; a modulus below two behaves as one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= stc_pkg::NODE_COUNT_RST;
      modulus_r    <= stc_pkg::MODULUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        stc_pkg::CFG_NODE_COUNT: node_count_r <= cfg_data[stc_pkg::NC_W-1:0];
        stc_pkg::CFG_MODULUS:    modulus_r    <= cfg_data;
        default:                 modulus_r    <= modulus_r;
      endcase
    end
  end

  assign m_eff = (modulus_r < stc_pkg::DATA_W'(2)) ? stc_pkg::DATA_W'(1) : modulus_r;
  // Node counts above the matrix size saturate.
  assign n_eff = (int'(node_count_r) > stc_pkg::MAX_NODES) ?
                 stc_pkg::CNT_W'(stc_pkg::MAX_NODES) : stc_pkg::CNT_W'(node_count_r);

  stc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_endpoint_a (in_endpoint_a),
    .in_endpoint_b (in_endpoint_b),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .n_eff         (n_eff),
    .stat          (stat),
    .cmd           (cmd)
  );

  stc_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .m_eff      (m_eff),
    .stat       (stat),
    .tree_count (out_tree_count)
  );

  // A determinant word always leaves the idle state at once.
  `STC_ASSERT(a_det_blocks, in_valid && in_ready && in_mode |=> !in_ready, "det word not blocking")
  // Clearing writes never overlap accepting a word.
  `STC_ASSERT_ALWAYS(a_clr_idle, !(cmd.we && cmd.wsel == stc_pkg::WS_ZERO && in_ready), "clear while ready")
  // The result register is loaded only when the slot is free or being drained.
  `STC_ASSERT(a_out_load, cmd.ld_out |-> !out_valid || out_ready, "result overwritten")

endmodule

FILE: tb/sv/spanning_tree_count_checker.sv
// ---------------------------------------------------------------------------
// Spanning tree count checker
// Watches the edge, result and register ports of the spanning tree counter,
// keeps its own Laplacian copy, predicts each tree count and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module spanning_tree_count_checker
  import stc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_mode,
  input  logic [EP_W-1:0]      in_endpoint_a,
  input  logic [EP_W-1:0]      in_endpoint_b,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [DATA_W-1:0]    out_tree_count,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  logic [DATA_W-1:0] lap [MAX_NODES][MAX_NODES];
  logic [NC_W-1:0]   node_reg;
  logic [DATA_W-1:0] mod_reg;
  logic [DATA_W-1:0] tree_count_q [$];

  function automatic longint unsigned active_mod();
    return (mod_reg < 2) ? 64'd1 : longint'(mod_reg);
  endfunction

  function automatic int active_nodes();
    return (node_reg > MAX_NODES) ? MAX_NODES : int'(node_reg);
  endfunction

  function automatic void clear_matrix();
    foreach (lap[r, c]) lap[r][c] = '0;
  endfunction

  function automatic void bump(int r, int c, bit up);
    longint unsigned m;
    longint unsigned v;
    m = active_mod();
    v = longint'(lap[r][c]) % m;
    v = up ? (v + 1) % m : (v + m - 1) % m;
    lap[r][c] = v[DATA_W-1:0];
  endfunction

  // Determinant of the minor without the last vertex, by repeated row
  // division and swapping; each swap negates the running product.
  function automatic logic [DATA_W-1:0] minor_determinant();
    longint unsigned m;
    longint unsigned acc;
    longint unsigned t;
    longint unsigned sub;
    longint unsigned v;
    int dim;
    m = active_mod();
    dim = (active_nodes() > 0) ? active_nodes() - 1 : 0;
    acc = 1 % m;
    for (int i = 0; i < dim; i++)
      for (int k = 0; k < dim; k++)
        lap[i][k] = DATA_W'(longint'(lap[i][k]) % m);
    for (int i = 0; i < dim; i++) begin
      for (int j = i + 1; j < dim; j++) begin
        while (lap[j][i] != 0) begin
          t = longint'(lap[i][i]) / longint'(lap[j][i]);
          for (int k = i; k < dim; k++) begin
            sub = (t * longint'(lap[j][k])) % m;
            v = (longint'(lap[i][k]) + m - sub) % m;
            lap[i][k] = lap[j][k];
            lap[j][k] = v[DATA_W-1:0];
          end
          acc = (m - acc) % m;
        end
      end
      acc = (acc * longint'(lap[i][i])) % m;
    end
    return acc[DATA_W-1:0];
  endfunction

  task automatic report(input string what, input logic [DATA_W-1:0] got,
                        input logic [DATA_W-1:0] want);
    $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    int n;
    logic [DATA_W-1:0] want;
    if (!rst_n) begin
      clear_matrix();
      node_reg = NODE_COUNT_RST;
      mod_reg = MODULUS_RST;
      tree_count_q.delete();
      pending = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_NODE_COUNT) node_reg = cfg_data[NC_W-1:0];
        else if (cfg_index == CFG_MODULUS) mod_reg = cfg_data;
      end
      // A result can never share an edge with the word that caused it.
      if (out_valid && out_ready) begin
        if (tree_count_q.size() == 0) begin
          report("tree_count with nothing outstanding", out_tree_count, '0);
        end else begin
          want = tree_count_q.pop_front();
          if (out_tree_count !== want) report("tree_count", out_tree_count, want);
        end
      end
      if (in_valid && in_ready) begin
        if (in_mode == 1'b0) begin
          n = active_nodes();
          if (in_endpoint_a < n && in_endpoint_b < n && in_endpoint_a != in_endpoint_b) begin
            bump(in_endpoint_a, in_endpoint_a, 1'b1);
            bump(in_endpoint_b, in_endpoint_b, 1'b1);
            bump(in_endpoint_a, in_endpoint_b, 1'b0);
            bump(in_endpoint_b, in_endpoint_a, 1'b0);
          end
        end else begin
          tree_count_q.push_back(minor_determinant());
          clear_matrix();
        end
      end
      pending = tree_count_q.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// Spanning tree counter testbench
// Drives edge and determinant words with random gaps and receiver stalls,
// reprograms node count and modulus between phases, and lets the checker
// compare every tree count with its own prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import stc_pkg::*;

  localparam int RANDOM_WORDS = 1350;
  // Idle time after the last result: covers the clearing pass after a
  // determinant as well as an edge word still in flight.
  localparam int SETTLE_CYCLES = 4600;
  // The stop sits far above a normal run, even one with a determinant on a
  // seven-row minor with worst-case Euclid runs.
  localparam int CYCLE_LIMIT = 80000000;
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_DET = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_mode = 1'b0;
  logic [EP_W-1:0] in_endpoint_a = '0;
  logic [EP_W-1:0] in_endpoint_b = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DATA_W-1:0] out_tree_count;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int words_sent = 0;
  int node_setting = 1;
  bit no_gaps = 1'b0;
  bit long_hold_req = 1'b0;

  always #2 clk = ~clk;

  spanning_tree_count_mod dut (.*);

  spanning_tree_count_checker checker_i (.*);

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random ready with short and occasional long stalls, plus one
  // very long hold-off on request so the result register backs up and the
  // block stops taking words.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (40000) @(negedge clk);
        long_hold_req = 1'b0;
      end else if (no_gaps) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) out_ready <= 1'b1;
        else begin
          out_ready <= 1'b0;
          stall_left = (r < 93) ? $urandom_range(0, 3) : $urandom_range(20, 300);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  // Offers one word and returns once it has been taken.
  task automatic send_word(input logic mode, input int a, input int b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_mode <= mode;
    in_endpoint_a <= a[EP_W-1:0];
    in_endpoint_b <= b[EP_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic add_edge(input int a, input int b);
    send_word(MODE_EDGE, a, b);
  endtask

  task automatic count_trees();
    send_word(MODE_DET, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  // Drops valid, waits for every outstanding tree count and lets the block
  // finish any clearing or edge update still running.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_COUNT) node_setting = int'(val[NC_W-1:0]);
  endtask

  // Endpoint inside the current graph most of the time, anywhere otherwise.
  function automatic int pick_vertex();
    int lim;
    lim = (node_setting > MAX_NODES) ? MAX_NODES : node_setting;
    if (lim > 0 && $urandom_range(0, 99) < 85) return $urandom_range(0, lim - 1);
    return $urandom_range(0, 63);
  endfunction

  task automatic random_edge();
    int a;
    int b;
    a = pick_vertex();
    b = pick_vertex();
    if (a == b && $urandom_range(0, 3) != 0) b = pick_vertex();
    add_edge(a, b);
  endtask

  function automatic logic [DATA_W-1:0] pick_modulus();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return DATA_W'($urandom_range(2, 30));
    if (r < 45) return 30'h3FFF_FFFF;
    if (r < 50) return 30'd2;
    if (r < 53) return DATA_W'($urandom_range(0, 1));
    return DATA_W'($urandom());
  endfunction

  function automatic int pick_nodes();
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return $urandom_range(2, 8);
    if (r < 94) return $urandom_range(0, 1);
    return $urandom_range(9, 12);
  endfunction

  initial begin
    int edges;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // The block clears its matrix after reset; let that finish.
    repeat (SETTLE_CYCLES) @(posedge clk);

    // Reset defaults: a single vertex has exactly one spanning tree.
    count_trees();
    drain();
    write_reg(CFG_NODE_COUNT, 30'd0);
    count_trees();
    drain();

    // Four vertices, largest modulus, with a self-loop and an edge that
    // names a vertex outside the graph.
    write_reg(CFG_NODE_COUNT, 30'd4);
    write_reg(CFG_MODULUS, 30'h3FFF_FFFF);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 3);
    add_edge(3, 0);
    add_edge(0, 2);
    add_edge(1, 1);
    add_edge(0, 63);
    count_trees();
    drain();

    // Smallest legal modulus, then moduli below two.
    write_reg(CFG_MODULUS, 30'd2);
    write_reg(CFG_NODE_COUNT, 30'd3);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(2, 0);
    count_trees();
    drain();
    write_reg(CFG_MODULUS, 30'd1);
    add_edge(0, 1);
    add_edge(2, 1);
    count_trees();
    drain();
    write_reg(CFG_MODULUS, 30'd0);
    add_edge(1, 0);
    count_trees();
    drain();

    // Node count above the maximum saturates; edges on the top vertices, then
    // a shrink so those entries fall outside the minor. The modulus also
    // changes while entries are stored.
    write_reg(CFG_NODE_COUNT, 30'd127);
    write_reg(CFG_MODULUS, 30'd7);
    add_edge(63, 62);
    add_edge(0, 63);
    add_edge(0, 1);
    add_edge(1, 2);
    add_edge(0, 1);
    drain();
    write_reg(CFG_MODULUS, 30'd3);
    write_reg(CFG_NODE_COUNT, 30'd3);
    add_edge(2, 0);
    count_trees();
    drain();

    // Receiver holds off for a long time while words keep coming, so the
    // result register fills and input stalls behind it.
    write_reg(CFG_MODULUS, 30'd1000000007);
    write_reg(CFG_NODE_COUNT, 30'd3);
    long_hold_req = 1'b1;
    for (int p = 0; p < 3; p++) begin
      add_edge(0, 1);
      add_edge(1, 2);
      count_trees();
    end
    drain();

    // Random phases: well-formed edge runs, ending in a determinant for up to eight nodes,
    // with occasional noise and register changes only while the block is idle.
    while (words_sent < RANDOM_WORDS) begin
      no_gaps = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 1)) write_reg(CFG_NODE_COUNT, DATA_W'(pick_nodes()));
      if ($urandom_range(0, 1)) write_reg(CFG_MODULUS, pick_modulus());
      edges = $urandom_range(0, 24);
      for (int e = 0; e < edges; e++) begin
        random_edge();
        if (node_setting <= 8 && $urandom_range(0, 39) == 0) count_trees();
      end
      if (node_setting <= 8) count_trees();
      drain();
    end

    no_gaps = 1'b0;
    drain();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
